// ----- hw/rtl/rhc_pkg.sv -----
// shared constants, types and codes for the rgb to hsv converter
`default_nettype none

package rhc_pkg;

    localparam int COMPONENT_BITS    = 8;
    localparam int HUE_FRACTION_BITS = 6;

    // component width used inside the datapath
    localparam int CW = COMPONENT_BITS;

    // fixed widths of the channel fields
    localparam int FIELD_W = 8;
    localparam int HUE_W   = 15;

    // hue scale: one sixth and one full turn in fixed point
    localparam int HUE_SIXTH = 60 << HUE_FRACTION_BITS;
    localparam int HUE_TURN  = 360 << HUE_FRACTION_BITS;

    // quotient bits: hue ratio never exceeds one sixth, saturation never exceeds full scale
    localparam int HUE_QW = $clog2(HUE_SIXTH + 1);
    localparam int QW     = (HUE_QW > CW) ? HUE_QW : CW;
    localparam int DW     = QW + CW;

    // signed width for base plus or minus ratio, before wrap
    localparam int HW = $clog2(HUE_TURN) + 2;

    typedef logic [CW-1:0] comp_t;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } sel_t;

    typedef struct packed {
        logic  max_zero;
        logic  delta_zero;
        logic  neg;
        sel_t  sel;
        comp_t brightness;
    } side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rhc_ifs.sv -----
// pixel and hsv stream interfaces
`default_nettype none

interface rhc_rgb_if
    import rhc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if
    import rhc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [HUE_W-1:0]   hue;
    logic               hue_valid;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] brightness;

    modport source (output valid, output hue, output hue_valid, output saturation,
                    output brightness, input ready);
    modport sink   (input valid, input hue, input hue_valid, input saturation,
                    input brightness, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rhc_prep.sv -----
// front stages: max, min, hue sector, difference, then divider operands
`default_nettype none

module rhc_prep
    import rhc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire comp_t         red,
    input  wire comp_t         green,
    input  wire comp_t         blue,
    output logic               out_valid,
    output logic [DW-1:0]      hue_num,
    output logic [DW-1:0]      sat_num,
    output comp_t              hue_den,
    output comp_t              sat_den,
    output side_t              side
);

    // stage a registers
    logic  va_reg;
    comp_t mx_a_reg, mx_a_next;
    comp_t mn_a_reg, mn_a_next;
    comp_t mag_a_reg, mag_a_next;
    logic  neg_a_reg, neg_a_next;
    sel_t  sel_a_reg, sel_a_next;

    // stage b registers
    logic          vb_reg;
    logic [DW-1:0] hue_num_reg, hue_num_next;
    logic [DW-1:0] sat_num_reg, sat_num_next;
    comp_t         delta_reg, delta_next;
    comp_t         mx_b_reg;
    side_t         side_reg, side_next;

    logic r_top, g_top;
    comp_t d_gb, d_bg, d_br, d_rb, d_rg, d_gr;

    always_comb
    begin
        // first component equal to the max wins, red then green then blue
        r_top = (red >= green) && (red >= blue);
        g_top = !r_top && (green >= blue);

        d_gb = green - blue;
        d_bg = blue - green;
        d_br = blue - red;
        d_rb = red - blue;
        d_rg = red - green;
        d_gr = green - red;

        mx_a_next = (red > green) ? red : green;
        if (blue > mx_a_next)
        begin
            mx_a_next = blue;
        end
        mn_a_next = (red < green) ? red : green;
        if (blue < mn_a_next)
        begin
            mn_a_next = blue;
        end

        if (r_top)
        begin
            sel_a_next = SEL_RED;
            neg_a_next = green < blue;
            mag_a_next = neg_a_next ? d_bg : d_gb;
        end
        else if (g_top)
        begin
            sel_a_next = SEL_GREEN;
            neg_a_next = blue < red;
            mag_a_next = neg_a_next ? d_rb : d_br;
        end
        else
        begin
            sel_a_next = SEL_BLUE;
            neg_a_next = red < green;
            mag_a_next = neg_a_next ? d_gr : d_rg;
        end
    end

    always_comb
    begin
        delta_next   = mx_a_reg - mn_a_reg;
        hue_num_next = DW'(mag_a_reg) * DW'(HUE_SIXTH);
        // delta times full scale, full scale being all ones
        sat_num_next = (DW'(delta_next) << CW) - DW'(delta_next);

        side_next.max_zero   = (mx_a_reg == '0);
        side_next.delta_zero = (delta_next == '0);
        side_next.neg        = neg_a_reg;
        side_next.sel        = sel_a_reg;
        side_next.brightness = mx_a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_a_reg    <= mx_a_next;
            mn_a_reg    <= mn_a_next;
            mag_a_reg   <= mag_a_next;
            neg_a_reg   <= neg_a_next;
            sel_a_reg   <= sel_a_next;
            hue_num_reg <= hue_num_next;
            sat_num_reg <= sat_num_next;
            delta_reg   <= delta_next;
            mx_b_reg    <= mx_a_reg;
            side_reg    <= side_next;
        end
    end

    assign out_valid = vb_reg;
    assign hue_num   = hue_num_reg;
    assign sat_num   = sat_num_reg;
    assign hue_den   = delta_reg;
    assign sat_den   = mx_b_reg;
    assign side      = side_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rhc_div_pipe.sv -----
// pipelined restoring divider, two lanes, one quotient bit per stage
`default_nettype none

module rhc_div_pipe
    import rhc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] hue_num,
    input  wire logic [DW-1:0] sat_num,
    input  wire comp_t         hue_den,
    input  wire comp_t         sat_den,
    input  wire side_t         side_in,
    output logic               out_valid,
    output logic [QW-1:0]      hue_q,
    output logic [QW-1:0]      sat_q,
    output side_t              side_out
);

    // work word: partial remainder on top, dividend bits then quotient bits below
    typedef struct packed {
        logic [DW-1:0] work;
        comp_t         den;
    } lane_t;

    function automatic lane_t div_step(lane_t x);
        logic [CW:0] t;
        logic [CW:0] diff;
        lane_t       y;
        t      = x.work[DW-1 -: CW+1];
        diff   = t - {1'b0, x.den};
        y.den  = x.den;
        if (t >= {1'b0, x.den})
        begin
            y.work = {diff[CW-1:0], x.work[QW-2:0], 1'b1};
        end
        else
        begin
            y.work = {t[CW-1:0], x.work[QW-2:0], 1'b0};
        end
        return y;
    endfunction

    logic [QW-1:0] valid_reg;
    lane_t         hue_reg  [QW];
    lane_t         sat_reg  [QW];
    side_t         side_reg [QW];

    lane_t hue_in  [QW];
    lane_t sat_in  [QW];
    side_t side_st [QW];
    logic  [QW-1:0] valid_in;

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            assign hue_in[s]   = '{work: hue_num, den: hue_den};
            assign sat_in[s]   = '{work: sat_num, den: sat_den};
            assign side_st[s]  = side_in;
            assign valid_in[s] = in_valid;
        end
        else
        begin : g_next
            assign hue_in[s]   = hue_reg[s-1];
            assign sat_in[s]   = sat_reg[s-1];
            assign side_st[s]  = side_reg[s-1];
            assign valid_in[s] = valid_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_in[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hue_reg[s]  <= div_step(hue_in[s]);
                sat_reg[s]  <= div_step(sat_in[s]);
                side_reg[s] <= side_st[s];
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign hue_q     = hue_reg[QW-1].work[QW-1:0];
    assign sat_q     = sat_reg[QW-1].work[QW-1:0];
    assign side_out  = side_reg[QW-1];

endmodule

`default_nettype wire

// ----- hw/rtl/rhc_finish.sv -----
// hue base and sign, wrap into one turn, zero cases, output register
`default_nettype none

module rhc_finish
    import rhc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [QW-1:0] hue_q,
    input  wire logic [QW-1:0] sat_q,
    input  wire side_t         side,
    output logic               out_valid,
    output logic [HUE_W-1:0]   hue,
    output logic               hue_valid,
    output logic [FIELD_W-1:0] saturation,
    output logic [FIELD_W-1:0] brightness
);

    logic                valid_reg;
    logic [HUE_W-1:0]    hue_reg, hue_next;
    logic                hue_valid_reg, hue_valid_next;
    logic [FIELD_W-1:0]  sat_reg, sat_next;
    logic [FIELD_W-1:0]  bright_reg, bright_next;

    logic signed [HW-1:0] base;
    logic signed [HW-1:0] q_s;
    logic signed [HW-1:0] sum;
    logic signed [HW-1:0] wrapped;

    always_comb
    begin
        unique case (side.sel)
            SEL_RED:   base = '0;
            SEL_GREEN: base = HW'(2 * HUE_SIXTH);
            default:   base = HW'(4 * HUE_SIXTH);
        endcase

        q_s     = HW'(hue_q);
        sum     = side.neg ? (base - q_s) : (base + q_s);
        wrapped = sum[HW-1] ? (sum + HW'(HUE_TURN)) : sum;

        hue_valid_next = !side.max_zero && !side.delta_zero;
        hue_next       = hue_valid_next ? HUE_W'($unsigned(wrapped)) : '0;
        sat_next       = side.max_zero ? '0 : FIELD_W'(sat_q);
        bright_next    = FIELD_W'(side.brightness);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg       <= hue_next;
            hue_valid_reg <= hue_valid_next;
            sat_reg       <= sat_next;
            bright_reg    <= bright_next;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign hue_valid  = hue_valid_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
// rgb to hsv converter top level
//
//  channel  direction  payload                                  transaction when
//  rgb      sink       red, green, blue                         rgb.valid && rgb.ready
//  hsv      source     hue, hue_valid, saturation, brightness   hsv.valid && hsv.ready
//
// one pixel per clock sustained while the output is not stalled; the divider sets the pipeline
// depth, one quotient bit per stage
// two front stages form max, min and divider operands, one back stage forms hue
// reset clears only the valid bits; the pipeline is usable on the first cycle after reset
// a stalled output holds the whole pipeline; bubbles move forward while the
// output register is empty
`default_nettype none

module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rhc_rgb_if.sink    rgb,
    rhc_hsv_if.source  hsv
);

    logic en;

    logic          prep_valid;
    logic [DW-1:0] hue_num;
    logic [DW-1:0] sat_num;
    comp_t         hue_den;
    comp_t         sat_den;
    side_t         prep_side;

    logic          div_valid;
    logic [QW-1:0] hue_q;
    logic [QW-1:0] sat_q;
    side_t         div_side;

    logic          out_valid;

    assign en        = !out_valid || hsv.ready;
    assign rgb.ready = en;
    assign hsv.valid = out_valid;

    rhc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rgb.valid),
        .red       (CW'(rgb.red)),
        .green     (CW'(rgb.green)),
        .blue      (CW'(rgb.blue)),
        .out_valid (prep_valid),
        .hue_num   (hue_num),
        .sat_num   (sat_num),
        .hue_den   (hue_den),
        .sat_den   (sat_den),
        .side      (prep_side)
    );

    rhc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .hue_num   (hue_num),
        .sat_num   (sat_num),
        .hue_den   (hue_den),
        .sat_den   (sat_den),
        .side_in   (prep_side),
        .out_valid (div_valid),
        .hue_q     (hue_q),
        .sat_q     (sat_q),
        .side_out  (div_side)
    );

    rhc_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (div_valid),
        .hue_q      (hue_q),
        .sat_q      (sat_q),
        .side       (div_side),
        .out_valid  (out_valid),
        .hue        (hsv.hue),
        .hue_valid  (hsv.hue_valid),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness)
    );

endmodule

`default_nettype wire

// ----- verif/tb_rgb_to_hsv_converter.sv -----
// self-checking testbench for the rgb to hsv converter
module tb_rgb_to_hsv_converter;
    import rhc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = QW + 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PIXELS = 750;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
        int unsigned        gap;
        bit                 drain;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic               hue_valid;
        logic [FIELD_W-1:0] saturation;
        logic [FIELD_W-1:0] brightness;
    } hsv_t;

    logic clk;
    logic rst_n;

    rhc_rgb_if rgb_ch ();
    rhc_hsv_if hsv_ch ();

    rgb_to_hsv_converter uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rgb   (rgb_ch),
        .hsv   (hsv_ch)
    );

    pixel_t      pixels_to_send[$];
    hsv_t        hsv_expected[$];
    int unsigned pixels_taken;
    int unsigned total_pixels;
    int unsigned idle_left;
    int unsigned ready_left;
    int unsigned cycle_count;
    int unsigned fault_count;
    logic        rgb_taken;

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // expected hsv for one pixel
    function automatic hsv_t convert_pixel(input logic [FIELD_W-1:0] r_in,
                                           input logic [FIELD_W-1:0] g_in,
                                           input logic [FIELD_W-1:0] b_in);
        int   r, g, b;
        int   mx, mn, delta, diff, base, ratio, h;
        int   full;
        hsv_t res;
        r = comp_t'(r_in);
        g = comp_t'(g_in);
        b = comp_t'(b_in);
        full = (1 << CW) - 1;
        mx = (r > g) ? r : g;
        mn = (r < g) ? r : g;
        if (b > mx) mx = b;
        if (b < mn) mn = b;
        delta = mx - mn;
        res = '0;
        res.brightness = mx[FIELD_W-1:0];
        if (mx != 0)
        begin
            ratio = (delta * full) / mx;
            res.saturation = ratio[FIELD_W-1:0];
        end
        if (mx != 0 && delta != 0)
        begin
            // first component equal to the max wins, red before green before blue
            if (r == mx)
            begin
                base = 0;
                diff = g - b;
            end
            else if (g == mx)
            begin
                base = 2 * HUE_SIXTH;
                diff = b - r;
            end
            else
            begin
                base = 4 * HUE_SIXTH;
                diff = r - g;
            end
            ratio = (HUE_SIXTH * ((diff < 0) ? -diff : diff)) / delta;
            h = base + ((diff < 0) ? -ratio : ratio);
            if (h < 0) h += HUE_TURN;
            res.hue = h[HUE_W-1:0];
            res.hue_valid = 1'b1;
        end
        return res;
    endfunction

    function automatic pixel_t make_pixel(input int r, input int g, input int b,
                                          input int unsigned gap, input bit drain);
        pixel_t p;
        p.red   = r[FIELD_W-1:0];
        p.green = g[FIELD_W-1:0];
        p.blue  = b[FIELD_W-1:0];
        p.gap   = gap;
        p.drain = drain;
        return p;
    endfunction

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic pixel_t random_pixel(input int unsigned gap, input bit drain);
        int v[3];
        int top, pick;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
            v[i] = $urandom_range(0, 255);
        case (mode)
            5:
            begin
                // grey
                v[1] = v[0];
                v[2] = v[0];
            end
            6:
            begin
                // at least two components tie for the max
                top = $urandom_range(1, 255);
                pick = $urandom_range(0, 2);
                for (int i = 0; i < 3; i++)
                    v[i] = (i == pick) ? $urandom_range(0, top) : top;
            end
            7:
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = $urandom_range(0, 3);
            end
            8:
            begin
                for (int i = 0; i < 3; i++)
                    if ($urandom_range(0, 1) == 1) v[i] = ($urandom_range(0, 1) == 1) ? 255 : 0;
            end
            9:
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 0;
            end
            default: ;
        endcase
        return make_pixel(v[0], v[1], v[2], gap, drain);
    endfunction

    // predictor and checker, both on the rising edge
    always @(posedge clk)
    begin
        hsv_t got;
        hsv_t want;
        if (rgb_ch.valid && rgb_ch.ready && rst_n)
        begin
            hsv_expected.push_back(convert_pixel(rgb_ch.red, rgb_ch.green, rgb_ch.blue));
            pixels_taken <= pixels_taken + 1;
        end
        rgb_taken <= rst_n && rgb_ch.valid && rgb_ch.ready;

        if (hsv_ch.valid && hsv_ch.ready && rst_n)
        begin
            got.hue        = hsv_ch.hue;
            got.hue_valid  = hsv_ch.hue_valid;
            got.saturation = hsv_ch.saturation;
            got.brightness = hsv_ch.brightness;
            if (hsv_expected.size() == 0)
            begin
                fault_count <= fault_count + 1;
                if (fault_count < MAX_REPORTS)
                    $display("unexpected hsv transaction: hue %0d valid %0d sat %0d val %0d",
                             got.hue, got.hue_valid, got.saturation, got.brightness);
            end
            else
            begin
                want = hsv_expected.pop_front();
                if (got.hue !== want.hue || got.hue_valid !== want.hue_valid ||
                    got.saturation !== want.saturation || got.brightness !== want.brightness)
                begin
                    fault_count <= fault_count + 1;
                    if (fault_count < MAX_REPORTS)
                        $display("hsv mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.hue, want.hue_valid, want.saturation, want.brightness,
                                 got.hue, got.hue_valid, got.saturation, got.brightness);
                end
            end
        end
    end

    // pixel driver, falling edge
    always @(negedge clk)
    begin
        pixel_t cur;
        if (rst_n)
        begin
            if (rgb_ch.valid && !rgb_taken)
            begin
                // transaction still pending, hold
            end
            else if (idle_left > 0)
            begin
                idle_left <= idle_left - 1;
                rgb_ch.valid <= 1'b0;
            end
            else if (pixels_to_send.size() == 0)
                rgb_ch.valid <= 1'b0;
            else if (pixels_to_send[0].gap > 0)
            begin
                idle_left <= pixels_to_send[0].gap - 1;
                pixels_to_send[0].gap = 0;
                rgb_ch.valid <= 1'b0;
            end
            else if (pixels_to_send[0].drain && hsv_expected.size() != 0)
                rgb_ch.valid <= 1'b0;
            else
            begin
                cur = pixels_to_send.pop_front();
                rgb_ch.valid <= 1'b1;
                rgb_ch.red   <= cur.red;
                rgb_ch.green <= cur.green;
                rgb_ch.blue  <= cur.blue;
            end
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        int unsigned roll;
        if (ready_left > 0)
            ready_left <= ready_left - 1;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                hsv_ch.ready <= 1'b1;
                ready_left <= $urandom_range(0, 11);
            end
            else if (roll < 65)
            begin
                // long stretch without stalls
                hsv_ch.ready <= 1'b1;
                ready_left <= $urandom_range(150, 250);
            end
            else if (roll < 92)
            begin
                hsv_ch.ready <= 1'b0;
                ready_left <= $urandom_range(0, 2);
            end
            else
            begin
                hsv_ch.ready <= 1'b0;
                ready_left <= $urandom_range(15, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[rgb_to_hsv_converter] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [23:0] corner_cases[] = '{
            24'h000000, 24'hFFFFFF, 24'h010101, 24'h808080,
            24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFF0001,
            24'hFF0100, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
            24'h010000, 24'h000001, 24'h0001FF, 24'hFFFEFD,
            24'h010001, 24'hC864C8, 24'h0AFF0A, 24'h0080FF,
            24'hFF8040, 24'h55AAFF, 24'hFE00FF, 24'h7F0080
        };
        int unsigned gap;

        rst_n          = 1'b0;
        rgb_ch.valid   = 1'b0;
        rgb_ch.red     = '0;
        rgb_ch.green   = '0;
        rgb_ch.blue    = '0;
        hsv_ch.ready   = 1'b0;
        pixels_taken   = 0;
        idle_left      = 0;
        ready_left     = 0;
        cycle_count    = 0;
        fault_count    = 0;
        rgb_taken      = 1'b0;

        foreach (corner_cases[i])
            pixels_to_send.push_back(make_pixel(corner_cases[i][23:16], corner_cases[i][15:8],
                                                corner_cases[i][7:0], 0, 1'b0));
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            // a window of back to back pixels
            gap = (i >= 300 && i < 420) ? 0 : pick_gap();
            pixels_to_send.push_back(random_pixel(gap, (i % 200) == 0));
        end
        total_pixels = pixels_to_send.size();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (pixels_taken < total_pixels) @(negedge clk);
        while (hsv_expected.size() != 0) @(negedge clk);
        repeat (4 * LATENCY) @(negedge clk);

        if (fault_count == 0 && hsv_expected.size() == 0)
            $display("[rgb_to_hsv_converter] OK");
        else
            $display("[rgb_to_hsv_converter] ERROR");
        $finish;
    end

endmodule
